// ----- src/aesdec_pkg.sv -----
// Shared types, constants and byte functions for the AES-256 CBC decrypt unit.
// No dependencies.
`timescale 1ns / 1ps

package aesdec_pkg;

  localparam int ROUNDS    = 14;
  localparam int KEY_WORDS = 8;
  localparam int RK_COUNT  = ROUNDS + 1;
  localparam int RK_ADDR_W = $clog2(RK_COUNT);
  localparam int BLOCK_W   = 128;
  localparam int PADDR_W   = 6;

  // Register indexes (byte address / 8)
  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_IV_HI  = 3'd4;
  localparam logic [2:0] REG_IV_LO  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND
  } state_t;

  localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8), polynomial 0x11B
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Forward S-box on each byte of a word
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // InvShiftRows followed by InvSubBytes; byte i sits at bits 127-8i
  function automatic logic [BLOCK_W-1:0] inv_shift_sub(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(4*c+r) -: 8] = INV_SBOX[s[BLOCK_W-1-8*(4*((c-r+4)%4)+r) -: 8]];
      end
    end
    return t;
  endfunction

  // InvMixColumns on all four columns
  function automatic logic [BLOCK_W-1:0] inv_mix(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    logic [7:0] b [4];
    logic [7:0] m9 [4];
    logic [7:0] m11 [4];
    logic [7:0] m13 [4];
    logic [7:0] m14 [4];
    logic [7:0] x2, x4, x8;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        b[r]   = s[BLOCK_W-1-8*(4*c+r) -: 8];
        x2     = xtime(b[r]);
        x4     = xtime(x2);
        x8     = xtime(x4);
        m9[r]  = x8 ^ b[r];
        m11[r] = x8 ^ x2 ^ b[r];
        m13[r] = x8 ^ x4 ^ b[r];
        m14[r] = x8 ^ x4 ^ x2;
      end
      t[BLOCK_W-1-8*(4*c+0) -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
      t[BLOCK_W-1-8*(4*c+1) -: 8] = m9[0] ^ m14[1] ^ m11[2] ^ m13[3];
      t[BLOCK_W-1-8*(4*c+2) -: 8] = m13[0] ^ m9[1] ^ m14[2] ^ m11[3];
      t[BLOCK_W-1-8*(4*c+3) -: 8] = m11[0] ^ m13[1] ^ m9[2] ^ m14[3];
    end
    return t;
  endfunction

endpackage

// ----- src/aesdec_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module aesdec_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/aes256_cbc_decrypt_unit.sv -----
// AES-256 CBC decrypt unit: APB register file, key schedule, iterative round unit.
// Depends on aesdec_pkg and aesdec_ram.
`timescale 1ns / 1ps

// One ciphertext block goes from acceptance to result through the initial
// round-key XOR and then the inverse rounds, all through a single round unit
// fed from the round-key RAM (one 128-bit key read per cycle). The
// unit takes no new block until the current one has reached the output
// register. Writing any key register (addresses 0x00..0x18) starts a key
// expansion, one round key per cycle; in_ready stays low until it is done.
// IV registers sit at 0x20 and 0x28 and are picked up by blocks that carry
// first_block. All bytes are big-endian: byte 0 is in the top bits.
module aes256_cbc_decrypt_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aesdec_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [63:0]                   cipher_high,
  input  logic [63:0]                   cipher_low,
  input  logic                          first_block,
  input  logic                          last_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [63:0]                   plain_high,
  output logic [63:0]                   plain_low,
  output logic                          block_last
);
  import aesdec_pkg::*;

  // registers
  logic [63:0] key_reg [4];
  logic [63:0] iv_high, iv_low;
  logic [BLOCK_W-1:0] chain_value;
  state_t state, state_next;
  logic [RK_ADDR_W-1:0] exp_cnt;
  logic [RK_ADDR_W-1:0] rnd;
  logic [255:0] window;
  logic [BLOCK_W-1:0] blk, cipher;
  logic first_q, last_q;

  // combinational
  logic cfg_wr, key_wr, in_fire, out_fire, round_go;
  logic [2:0] reg_idx;
  logic ram_we;
  logic [RK_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [BLOCK_W-1:0] ram_wdata, rk;
  logic [31:0] sched_t;
  logic [BLOCK_W-1:0] sched_new;
  logic [BLOCK_W-1:0] round_x, round_next, chain_sel;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[PADDR_W-1:3];
  assign cfg_wr   = psel && penable && pwrite;
  assign key_wr   = cfg_wr && (reg_idx == REG_KEY0 || reg_idx == REG_KEY1 ||
                               reg_idx == REG_KEY2 || reg_idx == REG_KEY3);
  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign round_go = (rnd != '0) || !out_valid || out_ready;

  // register read
  always_comb begin
    unique case (reg_idx)
      REG_KEY0:  prdata = key_reg[0];
      REG_KEY1:  prdata = key_reg[1];
      REG_KEY2:  prdata = key_reg[2];
      REG_KEY3:  prdata = key_reg[3];
      REG_IV_HI: prdata = iv_high;
      REG_IV_LO: prdata = iv_low;
      default:   prdata = '0;
    endcase
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_reg[i] <= '0;
      iv_high <= '0;
      iv_low  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_KEY0:  key_reg[0] <= pwdata;
        REG_KEY1:  key_reg[1] <= pwdata;
        REG_KEY2:  key_reg[2] <= pwdata;
        REG_KEY3:  key_reg[3] <= pwdata;
        REG_IV_HI: iv_high <= pwdata;
        REG_IV_LO: iv_low  <= pwdata;
        default: ;
      endcase
    end
  end

  // key schedule step: four new words from the eight-word window
  always_comb begin
    if (!exp_cnt[0]) begin
      sched_t = sub_word({window[23:0], window[31:24]}) ^
                {RCON[3'(exp_cnt[RK_ADDR_W-1:1] - 1'b1)], 24'h0};
    end else begin
      sched_t = sub_word(window[31:0]);
    end
    sched_new[127:96] = window[255:224] ^ sched_t;
    sched_new[95:64]  = window[223:192] ^ sched_new[127:96];
    sched_new[63:32]  = window[191:160] ^ sched_new[95:64];
    sched_new[31:0]   = window[159:128] ^ sched_new[63:32];
  end

  // round-key RAM write side
  always_comb begin
    ram_we    = (state == ST_EXPAND);
    ram_waddr = exp_cnt;
    if (exp_cnt == RK_ADDR_W'(0)) begin
      ram_wdata = {key_reg[0], key_reg[1]};
    end else if (exp_cnt == RK_ADDR_W'(1)) begin
      ram_wdata = {key_reg[2], key_reg[3]};
    end else begin
      ram_wdata = sched_new;
    end
  end

  // round-key RAM read address, issued in the cycle before the key is used
  always_comb begin
    unique case (state)
      ST_LOAD:  ram_raddr = RK_ADDR_W'(ROUNDS - 1);
      ST_ROUND: ram_raddr = (rnd == '0) ? '0 : rnd - 1'b1;
      default:  ram_raddr = RK_ADDR_W'(ROUNDS);
    endcase
  end

  aesdec_ram #(
    .WIDTH (BLOCK_W),
    .DEPTH (RK_COUNT)
  ) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rk)
  );

  // shared inverse round unit
  always_comb begin
    round_x    = inv_shift_sub(blk) ^ rk;
    round_next = inv_mix(round_x);
    chain_sel  = first_q ? {iv_high, iv_low} : chain_value;
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    priority if (key_wr) begin
      state_next = ST_EXPAND;
    end else begin
      unique case (state)
        ST_IDLE:   if (in_fire) state_next = ST_LOAD;
        ST_EXPAND: if (exp_cnt == RK_ADDR_W'(ROUNDS)) state_next = ST_IDLE;
        ST_LOAD:   state_next = ST_ROUND;
        ST_ROUND:  if (rnd == '0 && round_go) state_next = ST_IDLE;
        default:   state_next = ST_IDLE;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      exp_cnt     <= '0;
      rnd         <= '0;
      out_valid   <= 1'b0;
      chain_value <= '0;
    end else begin
      state <= state_next;
      if (key_wr) begin
        exp_cnt <= '0;
      end else if (state == ST_EXPAND) begin
        exp_cnt <= exp_cnt + 1'b1;
      end
      if (state == ST_LOAD) begin
        rnd <= RK_ADDR_W'(ROUNDS - 1);
      end else if (state == ST_ROUND && rnd != '0) begin
        rnd <= rnd - 1'b1;
      end
      if (state == ST_ROUND && rnd == '0 && round_go) begin
        out_valid   <= 1'b1;
        chain_value <= cipher;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_EXPAND) begin
      if (exp_cnt == '0) begin
        window <= {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
      end else if (exp_cnt != RK_ADDR_W'(1)) begin
        window <= {window[127:0], sched_new};
      end
    end
    if (in_fire) begin
      cipher  <= {cipher_high, cipher_low};
      first_q <= first_block;
      last_q  <= last_block;
    end
    if (state == ST_LOAD) begin
      blk <= cipher ^ rk;
    end else if (state == ST_ROUND && rnd != '0) begin
      blk <= round_next;
    end
    if (state == ST_ROUND && rnd == '0 && round_go) begin
      {plain_high, plain_low} <= round_x ^ chain_sel;
      block_last <= last_q;
    end
  end

endmodule

// ----- src/aesdec_checker.sv -----
// Port-level checks for the AES-256 CBC decrypt unit, bound to the top level.
// Depends on aesdec_pkg.
`timescale 1ns / 1ps

module aesdec_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [aesdec_pkg::PADDR_W-1:0] paddr,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [63:0]                   plain_high,
  input logic [63:0]                   plain_low
);
  import aesdec_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(plain_high) && $stable(plain_low))
    else $error("stalled result changed");

  // an accepted request makes the unit busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a request needs all rounds before the next one can enter
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##14 !in_ready)
    else $error("request finished too early");

  // a key write starts the schedule and blocks requests
  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && paddr[PADDR_W-1:PADDR_W-1] == 1'b0 |=> !in_ready)
    else $error("ready during key expansion");

endmodule

bind aes256_cbc_decrypt_unit aesdec_checker u_aesdec_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .plain_high (plain_high),
  .plain_low  (plain_low)
);

// ----- dv/aes256_cbc_decrypt_unit_test.sv -----
// Testbench for the AES-256 CBC decrypt unit: directed and random blocks,
// checked against an in-bench predictor. Depends on aesdec_pkg and the unit.
`timescale 1ns / 1ps

module aes256_cbc_decrypt_unit_test;
  import aesdec_pkg::*;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready;
  logic [63:0] cipher_high, cipher_low;
  logic first_block, last_block;
  logic out_valid, out_ready;
  logic [63:0] plain_high, plain_low;
  logic block_last;

  aes256_cbc_decrypt_unit DUT (.*);

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } plain_t;

  // Predictor state
  logic [63:0] key_reg [4];
  logic [63:0] iv_reg [2];
  logic [63:0] chain_reg [2];
  logic [127:0] round_keys [RK_COUNT];
  plain_t plain_queue [$];

  int errors = 0;
  int cycles = 0;
  int hold_cycles = 0;
  bit random_stall = 1;
  localparam int CYCLE_LIMIT = 400000;

  // Clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("aes256_cbc_decrypt_unit_test failed");
      $finish;
    end
  end

  function automatic logic [7:0] fwd_sub(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = FWD_SBOX;
    return tbl[x];
  endfunction

  function automatic logic [7:0] inv_sub(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = INV_SBOX;
    return tbl[x];
  endfunction

  function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [3:0] m);
    logic [7:0] acc;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      if (m[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  // Standard AES-256 key schedule from the four key registers
  task automatic expand_schedule();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0] rc;
    for (int i = 0; i < 8; i++)
      w[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
    rc = 8'h01;
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]), fwd_sub(t[7:0])};
        t[31:24] ^= rc;
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = {fwd_sub(t[31:24]), fwd_sub(t[23:16]), fwd_sub(t[15:8]), fwd_sub(t[7:0])};
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < RK_COUNT; r++)
      round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  // Decrypt one block and chain it; byte i sits at bits 127-8i
  function automatic plain_t decrypt_block(input logic [63:0] ch, input logic [63:0] cl,
                                           input logic fb, input logic lb);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [127:0] blk;
    plain_t res;
    blk = {ch, cl} ^ round_keys[ROUNDS];
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int r = ROUNDS - 1; r >= 0; r--) begin
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          t[4*c+j] = inv_sub(s[4*((c-j+4)%4)+j]);
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ round_keys[r][127-8*i -: 8];
      if (r != 0) begin
        for (int c = 0; c < 4; c++) begin
          t[4*c]   = gf_times(s[4*c],14) ^ gf_times(s[4*c+1],11)
                   ^ gf_times(s[4*c+2],13) ^ gf_times(s[4*c+3],9);
          t[4*c+1] = gf_times(s[4*c],9) ^ gf_times(s[4*c+1],14)
                   ^ gf_times(s[4*c+2],11) ^ gf_times(s[4*c+3],13);
          t[4*c+2] = gf_times(s[4*c],13) ^ gf_times(s[4*c+1],9)
                   ^ gf_times(s[4*c+2],14) ^ gf_times(s[4*c+3],11);
          t[4*c+3] = gf_times(s[4*c],11) ^ gf_times(s[4*c+1],13)
                   ^ gf_times(s[4*c+2],9) ^ gf_times(s[4*c+3],14);
        end
        s = t;
      end
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    res.hi = blk[127:64] ^ (fb ? iv_reg[0] : chain_reg[0]);
    res.lo = blk[63:0] ^ (fb ? iv_reg[1] : chain_reg[1]);
    res.last = lb;
    chain_reg[0] = ch;
    chain_reg[1] = cl;
    return res;
  endfunction

  // APB write: setup phase, access phase, then idle; predictor follows
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= PADDR_W'(idx) << 3;
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (idx <= REG_KEY3) begin
      key_reg[idx] = value;
      expand_schedule();
    end else if (idx == REG_IV_HI) iv_reg[0] = value;
    else iv_reg[1] = value;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3);
    write_reg(REG_KEY0, k0);
    write_reg(REG_KEY1, k1);
    write_reg(REG_KEY2, k2);
    write_reg(REG_KEY3, k3);
  endtask

  // Send one request; the sender's idle gap is drawn per item.
  // Valid stays up after acceptance; the next call lowers it for a nonzero gap, and drain lowers it.
  task automatic send_block(input logic [63:0] ch, cl, input logic fb, lb);
    int gap;
    gap = random_stall ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    cipher_high <= ch;
    cipher_low <= cl;
    first_block <= fb;
    last_block <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    plain_queue.push_back(decrypt_block(ch, cl, fb, lb));
  endtask

  // Wait until every expected block is back, then let the unit settle
  task automatic drain();
    in_valid <= 0;
    while (plain_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Receiver: random stall per item, or a long hold-off when requested
  initial begin
    int wait_n;
    out_ready = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 0;
        hold_cycles <= hold_cycles - 1;
      end else if (out_ready && out_valid) begin
        wait_n = random_stall ? $urandom_range(0, 4) : 0;
        if (wait_n > 0) begin
          out_ready <= 0;
          repeat (wait_n) @(posedge clk);
        end
        out_ready <= 1;
      end else out_ready <= 1;
    end
  end

  // Result checker
  always @(posedge clk) begin
    plain_t exp_p;
    if (!rst && out_valid && out_ready) begin
      if (plain_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h %h", plain_high, plain_low);
      end else begin
        exp_p = plain_queue.pop_front();
        if (exp_p.hi !== plain_high || exp_p.lo !== plain_low ||
            exp_p.last !== block_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %h %h %b, got %h %h %b", exp_p.hi, exp_p.lo,
                     exp_p.last, plain_high, plain_low, block_last);
        end
      end
    end
  end

  // Known-answer block plus field extremes and chaining rules
  task automatic test_directed();
    load_key(64'h603deb1015ca71be, 64'h2b73aef0857d7781,
             64'h1f352c073b6108d7, 64'h2d9810a30914dff4);
    write_reg(REG_IV_HI, 64'h0001020304050607);
    write_reg(REG_IV_LO, 64'h08090a0b0c0d0e0f);
    send_block(64'h0, 64'h0, 0, 0);  // chain from reset value
    send_block(64'hf58c4c04d6e5f1ba, 64'h779eabfb5f7bfbd6, 1, 0);
    send_block(64'h9cfc4e967edb808d, 64'h679f777bc6702c7d, 0, 1);
    send_block('1, '1, 0, 1);
    send_block(64'h0, 64'h0, 1, 0);
    send_block(64'h8000000000000000, 64'h1, 0, 0);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1, 1);
    drain();
    // IV write alone takes effect only on the next flagged block
    write_reg(REG_IV_HI, '1);
    write_reg(REG_IV_LO, '1);
    send_block(64'h1234, 64'h5678, 0, 0);
    send_block(64'h1234, 64'h5678, 1, 0);
    drain();
    // Partial key update and extreme keys
    write_reg(REG_KEY2, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 0, 1);
    drain();
    load_key('1, '1, '1, '1);
    send_block('1, 64'h0, 1, 0);
    drain();
    load_key('0, '0, '0, '0);
    write_reg(REG_IV_HI, '0);
    write_reg(REG_IV_LO, '0);
    send_block(64'h0, '1, 1, 1);
    drain();
  endtask

  // Random CBC buffers, with new key and IV settings between phases
  task automatic test_random(input int phases, input int blocks);
    int len;
    int sent;
    for (int p = 0; p < phases; p++) begin
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
      write_reg(REG_IV_HI, {$urandom, $urandom});
      write_reg(REG_IV_LO, {$urandom, $urandom});
      sent = 0;
      while (sent < blocks) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len && sent < blocks; i++, sent++)
          send_block({$urandom, $urandom}, {$urandom, $urandom},
                     (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                     (i == len - 1) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
      drain();
    end
  endtask

  // Long receiver hold-off while blocks keep coming, then a no-gap burst
  task automatic test_backpressure();
    hold_cycles = 200;
    for (int i = 0; i < 30; i++)
      send_block({$urandom, $urandom}, {$urandom, $urandom}, i == 0, i == 29);
    drain();
    random_stall = 0;
    for (int i = 0; i < 40; i++)
      send_block({$urandom, $urandom}, {$urandom, $urandom}, i == 0, i == 39);
    drain();
    random_stall = 1;
  endtask

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    cipher_high = '0;
    cipher_low = '0;
    first_block = 0;
    last_block = 0;
    key_reg = '{default: '0};
    iv_reg = '{default: '0};
    chain_reg = '{default: '0};
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(12, 140);
    if (errors == 0 && plain_queue.size() == 0)
      $display("aes256_cbc_decrypt_unit_test passed");
    else
      $display("aes256_cbc_decrypt_unit_test failed");
    $finish;
  end
endmodule

// ----- sim.f -----
src/aesdec_pkg.sv
src/aesdec_ram.sv
src/aes256_cbc_decrypt_unit.sv
src/aesdec_checker.sv
dv/aes256_cbc_decrypt_unit_test.sv
